### sv/wav_data_chunk_extractor_core_assert.svh
// assertion macros for the wav data chunk extractor
// used by the top level only, no other dependencies
`ifndef WAV_DATA_CHUNK_EXTRACTOR_CORE_ASSERT_SVH
`define WAV_DATA_CHUNK_EXTRACTOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define WDCE_ASSERT_ALWAYS(lbl, clk_i, rst_ni, cond) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
		else $error("wdce check failed");
`define WDCE_ASSERT_IMPLY(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("wdce check failed");
`define WDCE_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("wdce check failed");
`else
`define WDCE_ASSERT_ALWAYS(lbl, clk_i, rst_ni, cond)
`define WDCE_ASSERT_IMPLY(lbl, clk_i, rst_ni, ante, cons)
`define WDCE_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons)
`endif
`endif

### sv/wdce_pkg.sv
// shared types and constants of the wav data chunk extractor
// no dependencies
package wdce_pkg;

	localparam int HEADER_WINDOW_DEF  = 1024;
	localparam int MIN_FILE_BYTES_DEF = 44;

	localparam logic [11:0] MIN_PAYLOAD_RST = 12'd1024;
	localparam logic [31:0] RIFF_ID = 32'h52494646;
	localparam logic [31:0] WAVE_ID = 32'h57415645;
	localparam logic [31:0] DATA_ID = 32'h64617461;
	localparam logic [12:0] COUNT_MAX = 13'h1FFF;

	typedef enum logic [4:0] {
		PH_MAGIC   = 5'b00001,
		PH_HEADER  = 5'b00010,
		PH_SKIP    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_FAIL    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       done_res;
		logic       success;
	} result_t;

	// character of a four character code, first character in the top byte
	function automatic logic [7:0] fourcc_char(input logic [31:0] id, input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = id[31:24];
			2'd1: c = id[23:16];
			2'd2: c = id[15:8];
			default: c = id[7:0];
		endcase
		return c;
	endfunction

endpackage

### sv/wav_data_chunk_extractor_core.sv
// top level of the wav data chunk extractor: input register, parser, result register
// depends on wdce_pkg, wdce_parser and wav_data_chunk_extractor_core_assert.svh
//
// usage
//  - s_* carries the file one byte per word, s_tlast on the final byte of a file
//  - m_* returns one word per payload byte and one word for the final byte
//    (a single word if the final byte is a payload byte); header and skipped bytes give no word
//  - m_tuser[0] flags a payload byte, m_tuser[1] flags success on the final word
//  - cfg_we/cfg_wdata set the payload threshold, only while the block is idle
// timing
//  - two register stages: input register, then parser into the result register driving m_*
//  - one byte per cycle unless m_tready stalls; bytes only touch small parse counters
// reset
//  - arst_n clears the parse state, empties both stages, threshold back to 1024
//  - after the final byte of a file the parse state clears on its own
// back-pressure
//  - with m_tvalid high and m_tready low the result register holds, a full input
//    register stays full and s_tready drops; no word is lost or repeated
module wav_data_chunk_extractor_core #(
	parameter int HEADER_WINDOW  = wdce_pkg::HEADER_WINDOW_DEF,
	parameter int MIN_FILE_BYTES = wdce_pkg::MIN_FILE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] file_byte
	input  logic        s_tlast,   // end_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_byte
	output logic [1:0]  m_tuser,   // [0] byte_valid, [1] success
	output logic        m_tlast,   // done_res
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata  // min_payload_bytes
);

	`include "wav_data_chunk_extractor_core_assert.svh"

	logic              in_valid_s1;
	logic [7:0]        byte_s1;
	logic              eof_s1;
	logic              out_valid_q;
	wdce_pkg::result_t res_q;
	wdce_pkg::result_t res;
	logic              res_valid;
	logic              out_free;
	logic              adv;
	logic [11:0]       min_payload_q;

	// result register can take a word when empty or being drained
	assign out_free = !out_valid_q || m_tready;
	assign adv      = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || out_free;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_payload_q <= wdce_pkg::MIN_PAYLOAD_RST;
		else if (cfg_we)
			min_payload_q <= cfg_wdata;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_tready)
			in_valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
	end

	// parse logic sits between the two registers, state moves on each advance
	wdce_parser #(
		.HEADER_WINDOW (HEADER_WINDOW),
		.MIN_FILE_BYTES(MIN_FILE_BYTES)
	) u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (adv),
		.file_byte        (byte_s1),
		.end_of_file      (eof_s1),
		.min_payload_bytes(min_payload_q),
		.res_valid        (res_valid),
		.res              (res)
	);

	// result register; bytes with no result are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= adv && res_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid)
			res_q <= res;
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = res_q.data_byte;
	assign m_tuser[0] = res_q.byte_valid;
	assign m_tuser[1] = res_q.success;
	assign m_tlast    = res_q.done_res;

	// every word is a payload byte or the final word of a file
	`WDCE_ASSERT_IMPLY(a_word_has_cause, clk, arst_n, m_tvalid, m_tuser[0] || m_tlast)
	// success only reported on the final word
	`WDCE_ASSERT_IMPLY(a_success_on_last, clk, arst_n, m_tvalid && m_tuser[1], m_tlast)
	// non-payload words carry a zero byte
	`WDCE_ASSERT_IMPLY(a_zero_data, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == 8'd0)
	// a held input word stays in the input register
	`WDCE_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid_s1 && !out_free, in_valid_s1)

endmodule

### sv/wdce_parser.sv
// chunk walking state and the per-word parse logic
// depends on wdce_pkg
module wdce_parser #(
	parameter int HEADER_WINDOW  = wdce_pkg::HEADER_WINDOW_DEF,
	parameter int MIN_FILE_BYTES = wdce_pkg::MIN_FILE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        file_byte,
	input  logic              end_of_file,
	input  logic [11:0]       min_payload_bytes,
	output logic              res_valid,
	output wdce_pkg::result_t res
);

	localparam int POS_W  = $clog2(HEADER_WINDOW + 1);
	localparam int SKIP_W = $clog2(HEADER_WINDOW + 3);
	localparam logic [POS_W-1:0] POS_WIN  = POS_W'(HEADER_WINDOW);
	localparam logic [POS_W-1:0] POS_MINM = POS_W'(MIN_FILE_BYTES - 1);
	localparam logic [POS_W-1:0] POS_4    = POS_W'(4);
	localparam logic [POS_W-1:0] POS_8    = POS_W'(8);
	localparam logic [POS_W-1:0] POS_11   = POS_W'(11);
	localparam logic [POS_W-1:0] POS_12   = POS_W'(12);

	wdce_pkg::phase_t phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [31:0]       id_q, id_d;
	logic [31:0]       size_q, size_d;
	logic [2:0]        idx_q, idx_d;
	logic [SKIP_W-1:0] skip_q, skip_d;
	logic [12:0]       count_q, count_d;
	logic              emit;
	logic              ok;

	always_comb begin
		phase_d = phase_q;
		id_d    = id_q;
		size_d  = size_q;
		idx_d   = idx_q;
		skip_d  = skip_q;
		count_d = count_q;
		emit    = 1'b0;
		unique case (phase_q)
			wdce_pkg::PH_MAGIC: begin
				if (pos_q < POS_4 && file_byte != wdce_pkg::fourcc_char(wdce_pkg::RIFF_ID, pos_q[1:0]))
					phase_d = wdce_pkg::PH_FAIL;
				else if (pos_q >= POS_8 && pos_q < POS_12
						&& file_byte != wdce_pkg::fourcc_char(wdce_pkg::WAVE_ID, pos_q[1:0]))
					phase_d = wdce_pkg::PH_FAIL;
				else if (pos_q >= POS_11) begin
					phase_d = wdce_pkg::PH_HEADER;
					idx_d   = 3'd0;
				end
			end
			wdce_pkg::PH_HEADER: begin
				if (pos_q >= POS_WIN) begin
					phase_d = wdce_pkg::PH_FAIL;
				end else begin
					if (!idx_q[2]) begin
						id_d = {id_q[23:0], file_byte};
					end else begin
						unique case (idx_q[1:0])
							2'd0: size_d[7:0]   = file_byte;
							2'd1: size_d[15:8]  = file_byte;
							2'd2: size_d[23:16] = file_byte;
							default: size_d[31:24] = file_byte;
						endcase
					end
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						// header complete: id and size are both in
						if (id_q == wdce_pkg::DATA_ID) begin
							phase_d = wdce_pkg::PH_PAYLOAD;
						end else if (size_d > 32'(HEADER_WINDOW)) begin
							phase_d = wdce_pkg::PH_FAIL;
						end else begin
							skip_d  = SKIP_W'(size_d) + SKIP_W'(size_d[0]);
							phase_d = (skip_d == '0) ? wdce_pkg::PH_HEADER : wdce_pkg::PH_SKIP;
						end
						id_d   = '0;
						size_d = '0;
					end
				end
			end
			wdce_pkg::PH_SKIP: begin
				if (skip_q != '0)
					skip_d = skip_q - SKIP_W'(1);
				if (skip_d == '0)
					phase_d = wdce_pkg::PH_HEADER;
			end
			wdce_pkg::PH_PAYLOAD: begin
				emit = 1'b1;
				if (count_q < wdce_pkg::COUNT_MAX)
					count_d = count_q + 13'd1;
			end
			default: phase_d = wdce_pkg::PH_FAIL;
		endcase
		pos_d = (pos_q < POS_WIN) ? pos_q + POS_W'(1) : pos_q;
	end

	assign ok = (phase_d == wdce_pkg::PH_PAYLOAD) && (pos_q >= POS_MINM)
			&& (count_d > {1'b0, min_payload_bytes});

	assign res_valid      = emit || end_of_file;
	assign res.data_byte  = emit ? file_byte : 8'd0;
	assign res.byte_valid = emit;
	assign res.done_res   = end_of_file;
	assign res.success    = end_of_file && ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wdce_pkg::PH_MAGIC;
			pos_q   <= '0;
			id_q    <= '0;
			size_q  <= '0;
			idx_q   <= '0;
			skip_q  <= '0;
			count_q <= '0;
		end else if (step) begin
			if (end_of_file) begin
				// next file starts from a clean parse
				phase_q <= wdce_pkg::PH_MAGIC;
				pos_q   <= '0;
				id_q    <= '0;
				size_q  <= '0;
				idx_q   <= '0;
				skip_q  <= '0;
				count_q <= '0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				id_q    <= id_d;
				size_q  <= size_d;
				idx_q   <= idx_d;
				skip_q  <= skip_d;
				count_q <= count_d;
			end
		end
	end

endmodule
